FILE: rtl/rdd_pkg.sv
// Shared types and codes for the ranked discovery dedup table.
`timescale 1ns / 1ps

package rdd_pkg;

  // Link-local network 169.254.0.0/16 and its mask.
  localparam logic [31:0] LL_MASK = 32'hFFFF_0000;
  localparam logic [31:0] LL_NET  = 32'hA9FE_0000;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Status codes of a result item.
  typedef enum logic [2:0] {
    ST_APPEND  = 3'd0,
    ST_REPLACE = 3'd1,
    ST_DROP    = 3'd2,
    ST_FULL    = 3'd3,
    ST_READ    = 3'd4,
    ST_CLEAR   = 3'd5,
    ST_EMPTY   = 3'd6
  } status_e;

  // One stored reply.
  typedef struct packed {
    logic [1:0]  rank;
    logic        routed;
    logic [1:0]  protocol;
    logic [47:0] mac;
    logic [31:0] radio_addr;
    logic [31:0] iface_addr;
    logic [31:0] iface_mask;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    mem_rd;
    logic    rd_slot_sel;
    logic    idx_inc;
    logic    commit;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic hit;
    logic upgrade;
    logic full;
    logic read_ok;
  } sts_t;

endpackage

FILE: rtl/rdd_datapath.sv
// Datapath: item registers, slot memory, scan index, counters and result registers.
`timescale 1ns / 1ps

module rdd_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rdd_pkg::cmd_t        cmd_i,
  output rdd_pkg::sts_t        sts_o,
  input  logic [1:0]           protocol_i,
  input  logic [47:0]          mac_i,
  input  logic [31:0]          radio_addr_i,
  input  logic [31:0]          iface_addr_i,
  input  logic [31:0]          iface_mask_i,
  input  logic                 routed_probe_i,
  input  logic [3:0]           read_slot_i,
  output logic [2:0]           status_o,
  output logic [3:0]           slot_o,
  output logic [1:0]           rank_o,
  output logic [4:0]           entry_total_o,
  output logic [15:0]          drop_total_o,
  output logic [1:0]           out_protocol_o,
  output logic [47:0]          out_mac_o,
  output logic [31:0]          out_radio_addr_o,
  output logic [31:0]          out_iface_addr_o,
  output logic [31:0]          out_iface_mask_o,
  output logic                 out_routed_o
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int EXTW = (CW > 5) ? CW : 5;

  // Slot memory, no reset: only entries that were written are used in a result.
  rdd_pkg::entry_t mem [TABLE_DEPTH];
  rdd_pkg::entry_t rdata_q;

  rdd_pkg::entry_t item_q;
  logic [3:0]      read_slot_q;
  logic [CW-1:0]   idx_q, count_q, count_d;
  logic [15:0]     drop_q, drop_d;

  // Result registers.
  logic [2:0]      res_status_q;
  logic [3:0]      res_slot_q;
  logic [1:0]      res_rank_q;
  logic [4:0]      res_total_q;
  logic [15:0]     res_drop_q;
  rdd_pkg::entry_t res_entry_q;

  logic [1:0]      rank_in;
  logic [AW-1:0]   rd_addr;
  logic [CMPW-1:0] slot_ext, idx_ext, count_cmp;
  logic [EXTW-1:0] total_ext;
  logic            mem_we;
  rdd_pkg::entry_t item_in;

  // Rank of the incoming reply.
  always_comb begin
    if (routed_probe_i || (iface_addr_i == '0)) begin
      rank_in = 2'd2;
    end else if ((iface_mask_i != '0) &&
                 (((iface_addr_i ^ radio_addr_i) & iface_mask_i) == '0)) begin
      rank_in = 2'd3;
    end else if ((iface_addr_i & rdd_pkg::LL_MASK) != rdd_pkg::LL_NET) begin
      rank_in = 2'd1;
    end else begin
      rank_in = 2'd0;
    end
  end

  always_comb begin
    item_in.rank       = rank_in;
    item_in.routed     = routed_probe_i;
    item_in.protocol   = protocol_i;
    item_in.mac        = mac_i;
    item_in.radio_addr = radio_addr_i;
    item_in.iface_addr = iface_addr_i;
    item_in.iface_mask = iface_mask_i;
  end

  // Widened views for compares and narrow result fields.
  assign slot_ext  = CMPW'(read_slot_q);
  assign idx_ext   = CMPW'(idx_q);
  assign count_cmp = CMPW'(count_q);
  assign rd_addr   = cmd_i.rd_slot_sel ? slot_ext[AW-1:0] : idx_q[AW-1:0];

  // Status toward the controller.
  always_comb begin
    sts_o.scan_end = (idx_q >= count_q);
    sts_o.full     = (count_q == CW'(TABLE_DEPTH));
    sts_o.read_ok  = (slot_ext < count_cmp);
    sts_o.upgrade  = (item_q.rank > rdata_q.rank);
    if ((item_q.mac != '0) || (rdata_q.mac != '0)) begin
      sts_o.hit = (item_q.protocol == rdata_q.protocol) && (item_q.mac == rdata_q.mac);
    end else begin
      sts_o.hit = (item_q.protocol == rdata_q.protocol) &&
                  (item_q.radio_addr == rdata_q.radio_addr);
    end
  end

  assign mem_we = cmd_i.commit &&
                  ((cmd_i.status == rdd_pkg::ST_APPEND) ||
                   (cmd_i.status == rdd_pkg::ST_REPLACE));

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q[AW-1:0]] <= item_q;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Next values of the counters at commit.
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    case (cmd_i.status)
      rdd_pkg::ST_APPEND: count_d = count_q + CW'(1);
      rdd_pkg::ST_REPLACE, rdd_pkg::ST_DROP: begin
        if (drop_q != 16'hFFFF) begin
          drop_d = drop_q + 16'd1;
        end
      end
      rdd_pkg::ST_CLEAR: begin
        count_d = '0;
        drop_d  = '0;
      end
      default: ;
    endcase
  end

  assign total_ext = EXTW'(count_d);

  // Control state of the datapath: scan index and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
      drop_q  <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        drop_q  <= drop_d;
      end
    end
  end

  // Item capture and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q      <= item_in;
      read_slot_q <= read_slot_i;
    end
    if (cmd_i.commit) begin
      res_status_q <= cmd_i.status;
      res_total_q  <= total_ext[4:0];
      res_drop_q   <= drop_d;
      res_entry_q  <= '0;
      res_slot_q   <= '0;
      res_rank_q   <= '0;
      case (cmd_i.status)
        rdd_pkg::ST_APPEND, rdd_pkg::ST_REPLACE, rdd_pkg::ST_DROP: begin
          res_slot_q <= idx_ext[3:0];
          res_rank_q <= item_q.rank;
        end
        rdd_pkg::ST_FULL: res_rank_q <= item_q.rank;
        rdd_pkg::ST_READ: begin
          res_slot_q  <= read_slot_q;
          res_rank_q  <= rdata_q.rank;
          res_entry_q <= rdata_q;
        end
        rdd_pkg::ST_EMPTY: res_slot_q <= read_slot_q;
        default: ;
      endcase
    end
  end

  assign status_o         = res_status_q;
  assign slot_o           = res_slot_q;
  assign rank_o           = res_rank_q;
  assign entry_total_o    = res_total_q;
  assign drop_total_o     = res_drop_q;
  assign out_protocol_o   = res_entry_q.protocol;
  assign out_mac_o        = res_entry_q.mac;
  assign out_radio_addr_o = res_entry_q.radio_addr;
  assign out_iface_addr_o = res_entry_q.iface_addr;
  assign out_iface_mask_o = res_entry_q.iface_mask;
  assign out_routed_o     = res_entry_q.routed;

endmodule

FILE: rtl/rdd_ctrl.sv
// Controller: sequences capture, slot scan, read and commit of each item.
`timescale 1ns / 1ps

module rdd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    operation_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rdd_pkg::sts_t sts_i,
  output rdd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_READ_RD,
    S_FINISH
  } state_e;

  state_e           state_q;
  rdd_pkg::status_e status_q;
  logic             out_valid_q;
  logic             accept, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Commands decoded from the state.
  always_comb begin
    cmd_o.capture     = accept;
    cmd_o.mem_rd      = ((state_q == S_SCAN_RD) && !sts_i.scan_end) ||
                        (state_q == S_READ_RD);
    cmd_o.rd_slot_sel = (state_q == S_READ_RD);
    cmd_o.idx_inc     = (state_q == S_SCAN_CMP) && !sts_i.hit;
    cmd_o.commit      = (state_q == S_FINISH) && out_free;
    cmd_o.status      = status_q;
  end

  // State, pending status and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= rdd_pkg::ST_APPEND;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (rdd_pkg::op_e'(operation_i))
              rdd_pkg::OP_INSERT: state_q <= S_SCAN_RD;
              rdd_pkg::OP_READ:   state_q <= S_READ_RD;
              rdd_pkg::OP_CLEAR: begin
                status_q <= rdd_pkg::ST_CLEAR;
                state_q  <= S_FINISH;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (sts_i.scan_end) begin
            status_q <= sts_i.full ? rdd_pkg::ST_FULL : rdd_pkg::ST_APPEND;
            state_q  <= S_FINISH;
          end else begin
            state_q <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (sts_i.hit) begin
            status_q <= sts_i.upgrade ? rdd_pkg::ST_REPLACE : rdd_pkg::ST_DROP;
            state_q  <= S_FINISH;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_READ_RD: begin
          status_q <= sts_i.read_ok ? rdd_pkg::ST_READ : rdd_pkg::ST_EMPTY;
          state_q  <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ranked_discovery_dedup_table.sv
// Top level of the ranked discovery dedup table.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one item: an insert of a
//   discovery reply, a read of a stored slot, or a clear of the table.
//   Output channel (out_valid_o/out_ready_i) returns one result item for
//   each insert, read or clear; an unused operation code is taken and
//   gives no result.
//   One item is in work at a time. An insert scans the stored slots in
//   order through the single read port of the slot memory, with a read
//   state and a compare state per slot compared. The scan ends at the
//   first match or after the last stored slot, and the result is then
//   committed. A read makes a single slot memory read before its commit;
//   a clear commits without a memory read.
//   The result sits in an output register; the block accepts the next item
//   as soon as the result is loaded, even while the receiver stalls. A
//   following item runs until its own result is ready, then waits for the
//   output register to empty.
//   Reset empties the table and zeroes the stored and duplicate counts;
//   slot contents are not cleared and are never used before being written.
`timescale 1ns / 1ps

module ranked_discovery_dedup_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  protocol_i,
  input  logic [47:0] mac_i,
  input  logic [31:0] radio_addr_i,
  input  logic [31:0] iface_addr_i,
  input  logic [31:0] iface_mask_i,
  input  logic        routed_probe_i,
  input  logic [3:0]  read_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [1:0]  rank_o,
  output logic [4:0]  entry_total_o,
  output logic [15:0] drop_total_o,
  output logic [1:0]  out_protocol_o,
  output logic [47:0] out_mac_o,
  output logic [31:0] out_radio_addr_o,
  output logic [31:0] out_iface_addr_o,
  output logic [31:0] out_iface_mask_o,
  output logic        out_routed_o
);

  rdd_pkg::cmd_t cmd;
  rdd_pkg::sts_t sts;

  // Sequencing.
  rdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, compare and result formatting.
  rdd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .protocol_i       (protocol_i),
    .mac_i            (mac_i),
    .radio_addr_i     (radio_addr_i),
    .iface_addr_i     (iface_addr_i),
    .iface_mask_i     (iface_mask_i),
    .routed_probe_i   (routed_probe_i),
    .read_slot_i      (read_slot_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .rank_o           (rank_o),
    .entry_total_o    (entry_total_o),
    .drop_total_o     (drop_total_o),
    .out_protocol_o   (out_protocol_o),
    .out_mac_o        (out_mac_o),
    .out_radio_addr_o (out_radio_addr_o),
    .out_iface_addr_o (out_iface_addr_o),
    .out_iface_mask_o (out_iface_mask_o),
    .out_routed_o     (out_routed_o)
  );

`ifndef NO_ASSERTIONS
  // A result is only loaded when the output register is free.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a pending result");

  // A loaded result is presented in the next cycle.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("loaded result not presented");

  // The memory port is never read and written in the same cycle.
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_rd |-> !cmd.commit)
    else $error("memory read and commit collide");

  // A clear result reports empty counters.
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rdd_pkg::ST_CLEAR)) |->
      ((entry_total_o == '0) && (drop_total_o == '0)))
    else $error("clear left nonzero counters");
`endif

endmodule
